[hw/rtl/psl_pkg.sv]
package psl_pkg;
    localparam int SEGMENTS_DEF = 20;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int REGION_W = 5;
    localparam int VALUE_W = 17;
    localparam int CFG_W = 5;
    localparam int IDX_W = 5;
    localparam logic [CFG_W-1:0] ADD_COUNT_RESET = CFG_W'(11);
    localparam logic OP_CONVERT = 1'b0;
    localparam logic OP_WRITE = 1'b1;
    localparam int QUEUE_DEPTH = 2;
endpackage

[hw/rtl/psl_if.sv]
interface psl_in_if #(parameter int SAMPLE_BITS = 16) ();
    logic valid;
    logic ready;
    logic opcode;
    logic [SAMPLE_BITS-1:0] sample;
    logic [4:0] entry_index;
    logic [SAMPLE_BITS-1:0] entry_low;
    logic [SAMPLE_BITS-1:0] entry_high;
    logic [SAMPLE_BITS-1:0] entry_slope;
    logic [SAMPLE_BITS-1:0] entry_constant;
    modport source (output valid, opcode, sample, entry_index, entry_low, entry_high,
                    entry_slope, entry_constant, input ready);
    modport sink (input valid, opcode, sample, entry_index, entry_low, entry_high,
                  entry_slope, entry_constant, output ready);
endinterface

interface psl_out_if ();
    logic valid;
    logic ready;
    logic [4:0] region;
    logic [16:0] linear_value;
    logic slope_error;
    modport source (output valid, region, linear_value, slope_error, input ready);
    modport sink (input valid, region, linear_value, slope_error, output ready);
endinterface

[hw/rtl/psl_front.sv]
// front: segment table, parallel range match, numerator forming
module psl_front
    import psl_pkg::*;
#(
    parameter int SEGMENTS = SEGMENTS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    psl_in_if.sink in_ch,
    input  logic [CFG_W-1:0] add_count,
    input  logic take,
    output logic job_valid,
    output logic [REGION_W-1:0] job_region,
    output logic [SAMPLE_BITS:0] job_num,
    output logic [SAMPLE_BITS-1:0] job_slope,
    output logic job_err
);
    localparam int SEG_W = $clog2(SEGMENTS);
    logic [SEGMENTS-1:0] valid_reg;
    logic [SAMPLE_BITS-1:0] low_mem [SEGMENTS];
    logic [SAMPLE_BITS-1:0] high_mem [SEGMENTS];
    logic [SAMPLE_BITS-1:0] slope_mem [SEGMENTS];
    logic [SAMPLE_BITS-1:0] off_mem [SEGMENTS];
    logic [SEGMENTS-1:0] hit;
    logic found;
    logic [SEG_W-1:0] sel;
    logic [SAMPLE_BITS:0] num;
    logic [SAMPLE_BITS-1:0] s, o;
    logic out_valid_reg;
    logic [REGION_W-1:0] region_reg;
    logic [SAMPLE_BITS:0] num_reg;
    logic [SAMPLE_BITS-1:0] slope_reg;
    logic err_reg;
    logic acc;
    logic is_write;
    logic [SEG_W-1:0] widx;

    assign in_ch.ready = !out_valid_reg || take;
    assign acc = in_ch.valid && in_ch.ready;
    assign is_write = in_ch.opcode == OP_WRITE;
    assign widx = SEG_W'(in_ch.entry_index);

    // parallel range compare
    always_comb
    begin
        for (int i = 0; i < SEGMENTS; i++)
            hit[i] = valid_reg[i] && in_ch.sample >= low_mem[i] && in_ch.sample <= high_mem[i];
    end

    // priority pick, lowest index first
    always_comb
    begin
        found = 1'b0;
        sel = '0;
        for (int i = SEGMENTS - 1; i >= 0; i--)
            if (hit[i])
            begin
                found = 1'b1;
                sel = SEG_W'(i);
            end
    end

    // add or saturating subtract
    always_comb
    begin
        s = in_ch.sample;
        o = off_mem[sel];
        if (32'(sel) < 32'(add_count))
            num = {1'b0, s} + {1'b0, o};
        else if (s >= o)
            num = {1'b0, s - o};
        else
            num = '0;
    end

    // table writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (acc && is_write && 32'(in_ch.entry_index) < SEGMENTS)
            valid_reg[widx] <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (acc && is_write && 32'(in_ch.entry_index) < SEGMENTS)
        begin
            low_mem[widx] <= in_ch.entry_low;
            high_mem[widx] <= in_ch.entry_high;
            slope_mem[widx] <= in_ch.entry_slope;
            off_mem[widx] <= in_ch.entry_constant;
        end
    end

    // output stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_ch.ready)
            out_valid_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            if (is_write || !found)
            begin
                region_reg <= '0;
                num_reg <= '0;
                slope_reg <= '0;
                err_reg <= 1'b0;
            end
            else
            begin
                region_reg <= REGION_W'(32'(sel) + 1);
                num_reg <= num;
                slope_reg <= slope_mem[sel];
                err_reg <= slope_mem[sel] == '0;
            end
        end
    end

    assign job_valid = out_valid_reg;
    assign job_region = region_reg;
    assign job_num = num_reg;
    assign job_slope = slope_reg;
    assign job_err = err_reg;
endmodule

[hw/rtl/psl_divider.sv]
// back: pipelined restoring divider, one quotient bit per stage
module psl_divider
    import psl_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  logic [REGION_W-1:0] in_region,
    input  logic [SAMPLE_BITS:0] in_num,
    input  logic [SAMPLE_BITS-1:0] in_slope,
    input  logic in_err,
    psl_out_if.source out_ch
);
    localparam int NW = SAMPLE_BITS + 1;
    localparam int STAGES = NW;
    logic [STAGES:0] v_reg;
    logic [NW-1:0] q_reg [STAGES+1];
    logic [NW-1:0] r_reg [STAGES+1];
    logic [SAMPLE_BITS-1:0] d_reg [STAGES+1];
    logic [REGION_W-1:0] g_reg [STAGES+1];
    logic [STAGES:0] e_reg;
    logic adv;

    // whole pipe moves when the output slot frees
    assign adv = !v_reg[STAGES] || out_ch.ready;
    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[STAGES-1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            q_reg[0] <= in_num;
            r_reg[0] <= '0;
            d_reg[0] <= in_slope;
            g_reg[0] <= in_region;
            e_reg[0] <= in_err;
            for (int k = 0; k < STAGES; k++)
            begin : stg
                logic [NW:0] t;
                t = {r_reg[k], q_reg[k][NW-1]};
                d_reg[k+1] <= d_reg[k];
                g_reg[k+1] <= g_reg[k];
                e_reg[k+1] <= e_reg[k];
                if (t >= {2'b00, d_reg[k]})
                begin
                    r_reg[k+1] <= NW'(t - {2'b00, d_reg[k]});
                    q_reg[k+1] <= {q_reg[k][NW-2:0], 1'b1};
                end
                else
                begin
                    r_reg[k+1] <= NW'(t);
                    q_reg[k+1] <= {q_reg[k][NW-2:0], 1'b0};
                end
            end
        end
    end

    assign out_ch.valid = v_reg[STAGES];
    assign out_ch.region = g_reg[STAGES];
    assign out_ch.slope_error = e_reg[STAGES];
    assign out_ch.linear_value = (e_reg[STAGES] || g_reg[STAGES] == '0) ? '0
                                 : VALUE_W'(q_reg[STAGES]);
endmodule

[hw/rtl/piecewise_sensor_linearizer.sv]
// piecewise sensor linearizer: one transaction per cycle sustained while out_ch is
// ready. the front matches the sample against all table segments in parallel and
// hands a numerator and slope to a divider of SAMPLE_BITS+2 register stages (the first
// takes the job, then one quotient bit each). a table write yields one all-zero result.
module piecewise_sensor_linearizer
    import psl_pkg::*;
#(
    parameter int SEGMENTS = SEGMENTS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    psl_in_if.sink in_ch,
    psl_out_if.source out_ch,
    input  logic cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata
);
    logic [CFG_W-1:0] add_count_reg;
    logic job_valid, take, job_err;
    logic [REGION_W-1:0] job_region;
    logic [SAMPLE_BITS:0] job_num;
    logic [SAMPLE_BITS-1:0] job_slope;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            add_count_reg <= ADD_COUNT_RESET;
        else if (cfg_we)
            add_count_reg <= cfg_wdata;
    end

    psl_front #(.SEGMENTS(SEGMENTS), .SAMPLE_BITS(SAMPLE_BITS)) u_front (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .add_count(add_count_reg), .take(take),
        .job_valid(job_valid), .job_region(job_region), .job_num(job_num),
        .job_slope(job_slope), .job_err(job_err)
    );

    psl_divider #(.SAMPLE_BITS(SAMPLE_BITS)) u_div (
        .clk(clk), .rst_n(rst_n), .in_valid(job_valid), .in_ready(take),
        .in_region(job_region), .in_num(job_num), .in_slope(job_slope), .in_err(job_err),
        .out_ch(out_ch)
    );
endmodule

[hw/rtl/psl_checker.sv]
// port level checks
module psl_checker (
    input logic clk,
    input logic rst_n,
    input logic out_valid,
    input logic out_ready,
    input logic [4:0] region,
    input logic [16:0] linear_value,
    input logic slope_error
);
    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(region) && $stable(linear_value))
        else $error("result changed while stalled");
    // error implies zero value
    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && slope_error |-> linear_value == 17'd0)
        else $error("value on slope error");
    // error implies a region
    a_reg: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && slope_error |-> region != 5'd0)
        else $error("error without region");
    // no region implies zero value and no error
    a_none: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && region == 5'd0 |-> linear_value == 17'd0 && !slope_error)
        else $error("value without region");
endmodule

bind piecewise_sensor_linearizer psl_checker u_chk (
    .clk(clk), .rst_n(rst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .region(out_ch.region), .linear_value(out_ch.linear_value),
    .slope_error(out_ch.slope_error)
);

[dv/tb_piecewise_sensor_linearizer.sv]
`timescale 1ns / 100ps

module tb_piecewise_sensor_linearizer;
    import psl_pkg::*;

    typedef struct packed {
        logic [4:0]  region;
        logic [16:0] linear_value;
        logic        slope_error;
    } lin_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_W-1:0] cfg_wdata = '0;

    psl_in_if #(.SAMPLE_BITS(16)) in_ch ();
    psl_out_if out_ch ();

    piecewise_sensor_linearizer dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch.sink),
        .out_ch(out_ch.source),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    // predictor state: the segment table and add count
    logic        seg_valid [SEGMENTS_DEF];
    logic [15:0] seg_low [SEGMENTS_DEF];
    logic [15:0] seg_high [SEGMENTS_DEF];
    logic [15:0] seg_slope [SEGMENTS_DEF];
    logic [15:0] seg_offset [SEGMENTS_DEF];
    logic [CFG_W-1:0] add_count;

    lin_result_t expected_q[$];
    int errors = 0;
    bit idle_on = 1'b1;

    always #2 clk = ~clk;

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.opcode = OP_CONVERT;
        in_ch.sample = '0;
        in_ch.entry_index = '0;
        in_ch.entry_low = '0;
        in_ch.entry_high = '0;
        in_ch.entry_slope = '0;
        in_ch.entry_constant = '0;
        out_ch.ready = 1'b0;
    end

    // compute the linearized result for one transaction
    function automatic lin_result_t linearize(logic op, logic [15:0] smp, logic [4:0] idx,
                                              logic [15:0] lo, logic [15:0] hi,
                                              logic [15:0] slp, logic [15:0] cst);
        lin_result_t r;
        int hit;
        logic [16:0] num;
        r = '0;
        hit = -1;
        if (op == OP_WRITE)
        begin
            if (idx < SEGMENTS_DEF)
            begin
                seg_low[idx] = lo;
                seg_high[idx] = hi;
                seg_slope[idx] = slp;
                seg_offset[idx] = cst;
                seg_valid[idx] = 1'b1;
            end
            return r;
        end
        for (int i = SEGMENTS_DEF - 1; i >= 0; i--)
            if (seg_valid[i] && smp >= seg_low[i] && smp <= seg_high[i])
                hit = i;
        if (hit < 0)
            return r;
        r.region = 5'(hit + 1);
        if (seg_slope[hit] == 0)
        begin
            r.slope_error = 1'b1;
            return r;
        end
        if (hit < add_count)
            num = {1'b0, smp} + {1'b0, seg_offset[hit]};
        else
            num = (smp >= seg_offset[hit]) ? {1'b0, smp - seg_offset[hit]} : 17'd0;
        r.linear_value = num / seg_slope[hit];
        return r;
    endfunction

    // send one transaction, sometimes after a random gap
    task automatic send_item(logic op, logic [15:0] smp, logic [4:0] idx, logic [15:0] lo,
                             logic [15:0] hi, logic [15:0] slp, logic [15:0] cst);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.opcode <= op;
        in_ch.sample <= smp;
        in_ch.entry_index <= idx;
        in_ch.entry_low <= lo;
        in_ch.entry_high <= hi;
        in_ch.entry_slope <= slp;
        in_ch.entry_constant <= cst;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        expected_q.push_back(linearize(op, smp, idx, lo, hi, slp, cst));
    endtask

    task automatic convert(logic [15:0] smp);
        send_item(OP_CONVERT, smp, 5'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom));
    endtask

    task automatic load_segment(logic [4:0] idx, logic [15:0] lo, logic [15:0] hi,
                                logic [15:0] slp, logic [15:0] cst);
        send_item(OP_WRITE, 16'($urandom), idx, lo, hi, slp, cst);
    endtask

    // wait for the block to drain, then write the add count
    task automatic set_add_count(logic [CFG_W-1:0] val);
        in_ch.valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (25) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        add_count = val;
    endtask

    // result checker
    always @(posedge clk)
    begin
        lin_result_t exp_r;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_q.size() == 0)
            begin
                $error("unexpected transaction region=%0d", out_ch.region);
                errors++;
            end
            else
            begin
                exp_r = expected_q.pop_front();
                if (out_ch.region !== exp_r.region)
                begin
                    $error("region expected %0d actual %0d", exp_r.region, out_ch.region);
                    errors++;
                end
                if (out_ch.linear_value !== exp_r.linear_value)
                begin
                    $error("linear_value expected %0d actual %0d",
                           exp_r.linear_value, out_ch.linear_value);
                    errors++;
                end
                if (out_ch.slope_error !== exp_r.slope_error)
                begin
                    $error("slope_error expected %0d actual %0d",
                           exp_r.slope_error, out_ch.slope_error);
                    errors++;
                end
            end
        end
    end

    // sink stall bursts
    always @(posedge clk)
    begin
        int stall;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            stall = $urandom_range(1, 18);
            out_ch.ready <= 1'b0;
            repeat (stall) @(posedge clk);
        end
        out_ch.ready <= 1'b1;
    end

    task automatic test_directed();
        convert(16'd0);
        load_segment(5'd0, 16'd0, 16'd99, 16'd1, 16'd65535);
        load_segment(5'd1, 16'd50, 16'd200, 16'd3, 16'd10);
        load_segment(5'd2, 16'd300, 16'd250, 16'd5, 16'd0);
        load_segment(5'd3, 16'd300, 16'd400, 16'd0, 16'd0);
        load_segment(5'd19, 16'd1000, 16'd65535, 16'd65535, 16'd65535);
        load_segment(5'd20, 16'd0, 16'd65535, 16'd1, 16'd0);
        load_segment(5'd31, 16'd0, 16'd65535, 16'd1, 16'd0);
        load_segment(5'd12, 16'd500, 16'd999, 16'd2, 16'd700);
        convert(16'd0);
        convert(16'd99);
        convert(16'd150);
        convert(16'd260);
        convert(16'd350);
        convert(16'd600);
        convert(16'd800);
        convert(16'd65535);
        load_segment(5'd1, 16'd100, 16'd200, 16'd1, 16'd5);
        convert(16'd150);
        convert(16'd250);
    endtask

    task automatic test_add_count(logic [CFG_W-1:0] val);
        set_add_count(val);
        for (int i = 0; i < 8; i++)
            convert(16'($urandom_range(0, 1100)));
        convert(16'd65535);
    endtask

    task automatic test_random(int n);
        logic [15:0] lo;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                lo = 16'($urandom);
                load_segment(5'($urandom_range(0, 21)), lo,
                             $urandom_range(0, 7) == 0 ? 16'($urandom)
                                                       : 16'(lo + $urandom_range(0, 8000)),
                             $urandom_range(0, 9) == 0 ? 16'd0 : 16'($urandom),
                             16'($urandom));
            end
            else if ($urandom_range(0, 1) == 0)
                convert(16'($urandom));
            else
                convert(16'($urandom_range(0, 3000)));
        end
    endtask

    initial
    begin
        for (int i = 0; i < SEGMENTS_DEF; i++)
            seg_valid[i] = 1'b0;
        add_count = ADD_COUNT_RESET;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_add_count(5'd0);
        test_add_count(5'd20);
        test_add_count(5'd31);
        test_add_count(5'd3);
        test_random(350);
        set_add_count(5'($urandom_range(0, 31)));
        idle_on = 1'b0;
        test_random(150);
        in_ch.valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("FAIL");
        $finish;
    end
endmodule

[piecewise_sensor_linearizer.f]
hw/rtl/psl_pkg.sv
hw/rtl/psl_if.sv
hw/rtl/psl_front.sv
hw/rtl/psl_divider.sv
hw/rtl/piecewise_sensor_linearizer.sv
hw/rtl/psl_checker.sv
dv/tb_piecewise_sensor_linearizer.sv
